// ===== hdl/uartrb_pkg.sv =====
// Shared types and constants for the UART receive/transmit ring buffers.
`default_nettype none
package uartrb_pkg;

   localparam int RX_DEPTH_DEF = 32;
   localparam int TX_DEPTH_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int ERR_W   = 3;
   localparam int COUNT_W = 5;

   // Command codes carried in the request beat
   localparam logic [CMD_W-1:0] CMD_LINE_RX  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HOST_PUT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HOST_GET = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd5;

   // Sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'b000;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'b100;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] byte_in;
      logic              frame_flag;
      logic              overrun_flag;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic               no_data;
      logic               err_frame;
      logic               err_overrun;
      logic               err_overflow;
      logic               put_refused;
      logic [BYTE_W-1:0]  line_byte;
      logic               line_valid;
      logic               tx_request;
      logic [COUNT_W-1:0] rx_count;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } dp_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/uartrb_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface uartrb_req_if;
   logic                        valid;
   logic                        ready;
   uartrb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface uartrb_rsp_if;
   logic                        valid;
   logic                        ready;
   uartrb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/uartrb_ctrl.sv =====
// Sequencing state machine: capture, execute and load one beat at a time.
`default_nettype none
module uartrb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output uartrb_pkg::dp_cmd_type  dp_cmd
);
   import uartrb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      load_ok;

   assign load_ok        = !rsp_valid_ff || rsp_ready;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign dp_cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign dp_cmd.execute = (state_ff == ST_EXEC);
   assign dp_cmd.load    = (state_ff == ST_LOAD) && load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise on a load, hold while the sink stalls
         rsp_valid_ff <= dp_cmd.load || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               // hold until the output register is free
               if (load_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/uartrb_dpath.sv =====
// Ring pointers, byte stores, sticky error and response register.
`default_nettype none
module uartrb_dpath #(
   parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire uartrb_pkg::dp_cmd_type       dp_cmd,
   input  wire uartrb_pkg::req_payload_type  req_data,
   output uartrb_pkg::rsp_payload_type       rsp_data
);
   import uartrb_pkg::*;

   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int TX_PW = $clog2(TX_DEPTH);
   localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
   localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
   localparam logic [RX_PW:0]   RX_SPAN = (RX_PW+1)'(RX_DEPTH);

   logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
   logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

   req_payload_type   req_ff;
   rsp_payload_type   rsp_ff;
   logic [RX_PW-1:0]  rx_wr_ff, rx_rd_ff;
   logic [TX_PW-1:0]  tx_wr_ff, tx_rd_ff;
   logic [ERR_W-1:0]  err_ff;
   logic              irq_ff;
   logic [BYTE_W-1:0] rx_q_ff, tx_q_ff;
   logic              rd_hit_ff, no_data_ff, refused_ff, line_valid_ff;

   logic [RX_PW-1:0]  rx_wr_in, rx_rd_in;
   logic [TX_PW-1:0]  tx_wr_in, tx_rd_in;
   logic              rx_full, rx_empty, tx_full, tx_empty;
   logic [RX_PW:0]    rx_level;

   // Pre-incremented pointers with wrap at the last slot
   assign rx_wr_in = (rx_wr_ff == RX_LAST) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_in = (rx_rd_ff == RX_LAST) ? '0 : rx_rd_ff + 1'b1;
   assign tx_wr_in = (tx_wr_ff == TX_LAST) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd_in = (tx_rd_ff == TX_LAST) ? '0 : tx_rd_ff + 1'b1;

   assign rx_full  = (rx_wr_in == rx_rd_ff);
   assign rx_empty = (rx_wr_ff == rx_rd_ff);
   assign tx_full  = (tx_wr_in == tx_rd_ff);
   assign tx_empty = (tx_wr_ff == tx_rd_ff);

   assign rx_level = (rx_wr_ff >= rx_rd_ff)
                   ? {1'b0, rx_wr_ff} - {1'b0, rx_rd_ff}
                   : {1'b0, rx_wr_ff} + RX_SPAN - {1'b0, rx_rd_ff};

   assign rsp_data = rsp_ff;

   // Byte stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         rx_q_ff <= rx_mem[rx_rd_in];
         tx_q_ff <= tx_mem[tx_rd_in];
         if (req_ff.cmd == CMD_LINE_RX && !rx_full) begin
            rx_mem[rx_wr_in] <= req_ff.byte_in;
         end
         if (req_ff.cmd == CMD_HOST_PUT && !tx_full) begin
            tx_mem[tx_wr_in] <= req_ff.byte_in;
         end
      end
   end

   // Beat capture, per-beat flags and response register
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_ff <= req_data;
      end
      if (dp_cmd.execute) begin
         rd_hit_ff     <= (req_ff.cmd inside {CMD_HOST_GET, CMD_PEEK}) && !rx_empty;
         no_data_ff    <= (req_ff.cmd inside {CMD_HOST_GET, CMD_PEEK}) && rx_empty;
         refused_ff    <= (req_ff.cmd == CMD_HOST_PUT) && tx_full;
         line_valid_ff <= (req_ff.cmd == CMD_TX_READY) && !tx_empty;
      end
      if (dp_cmd.load) begin
         rsp_ff.read_byte    <= rd_hit_ff ? rx_q_ff : '0;
         rsp_ff.no_data      <= no_data_ff;
         rsp_ff.err_frame    <= err_ff[0];
         rsp_ff.err_overrun  <= err_ff[1];
         rsp_ff.err_overflow <= err_ff[2];
         rsp_ff.put_refused  <= refused_ff;
         rsp_ff.line_byte    <= line_valid_ff ? tx_q_ff : '0;
         rsp_ff.line_valid   <= line_valid_ff;
         rsp_ff.tx_request   <= irq_ff;
         rsp_ff.rx_count     <= COUNT_W'(rx_level);
      end
   end

   // Pointer and flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff <= '0;
         rx_rd_ff <= '0;
         tx_wr_ff <= '0;
         tx_rd_ff <= '0;
         err_ff   <= ERR_NONE;
         irq_ff   <= 1'b0;
      end else if (dp_cmd.execute) begin
         case (req_ff.cmd)
            CMD_LINE_RX: begin
               if (rx_full) begin
                  err_ff <= ERR_OVERFLOW;
               end else begin
                  rx_wr_ff <= rx_wr_in;
                  err_ff   <= {1'b0, req_ff.overrun_flag, req_ff.frame_flag};
               end
            end
            CMD_HOST_PUT: begin
               if (!tx_full) begin
                  tx_wr_ff <= tx_wr_in;
                  irq_ff   <= 1'b1;
               end
            end
            CMD_HOST_GET: begin
               if (!rx_empty) begin
                  rx_rd_ff <= rx_rd_in;
               end
            end
            CMD_FLUSH: rx_wr_ff <= rx_rd_ff;
            CMD_TX_READY: begin
               if (tx_empty) begin
                  irq_ff <= 1'b0;
               end else begin
                  tx_rd_ff <= tx_rd_in;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/uart_rx_tx_ring_buffers.sv =====
// UART receive/transmit ring buffers, top level.
// Sequence: a request beat is captured, executed against the stores and then loaded
// into the response register, which drives the response channel directly.
// Flow: a new request is taken only once the previous beat is loaded (capture, store access, load);
// a pending response stalls only the load step.
// Reset: synchronous, clears pointers, sticky error and transmit request; stores are not cleared.
`default_nettype none
module uart_rx_tx_ring_buffers #(
   parameter int RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   uartrb_req_if.sink   req_chan,
   uartrb_rsp_if.source rsp_chan
);
   import uartrb_pkg::*;

   dp_cmd_type dp_cmd;

   uartrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd)
   );

   uartrb_dpath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .dp_cmd   (dp_cmd),
      .req_data (req_chan.payload),
      .rsp_data (rsp_chan.payload)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while a beat is in flight");

   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.err_overflow |->
         !rsp_chan.payload.err_frame && !rsp_chan.payload.err_overrun)
      else $error("overflow reported with line flags");

   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.no_data |->
         rsp_chan.payload.read_byte == '0)
      else $error("read byte set on empty read");

   a_line_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.line_valid |->
         rsp_chan.payload.line_byte == '0)
      else $error("line byte set without a pop");

endmodule
`default_nettype wire
